FILE: hw/rtl/tpet_pkg.sv
// Shared types, codes and defaults for the touch pen event tracker.
package tpet_pkg;

  // Default geometry of the filter.
  localparam int unsigned WindowDef     = 5;
  localparam int unsigned SampleBitsDef = 12;

  // Register and counter widths.
  localparam int unsigned ThreshBits  = 12;
  localparam int unsigned ReleaseBits = 3;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 12;
  localparam int unsigned IrqCntBits  = 16;
  localparam int unsigned KindBits    = 2;

  // Register reset values.
  localparam logic [ThreshBits-1:0]  ThreshReset  = ThreshBits'(5);
  localparam logic [ReleaseBits-1:0] ReleaseReset = ReleaseBits'(3);

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CFG_TOUCH_THRESHOLD = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CFG_RELEASE_CHECKS  = CfgIdxBits'(1);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_TRACK   = 2'd1,
    MODE_CONFIRM = 2'd2
  } mode_e;

  typedef enum logic [KindBits-1:0] {
    EV_DOWN = 2'd0,
    EV_MOVE = 2'd1,
    EV_UP   = 2'd2
  } event_kind_e;

endpackage

FILE: hw/rtl/tpet_median.sv
// Median of one sample window, found by ranking every entry in parallel.
module tpet_median #(
  parameter int unsigned WINDOW      = tpet_pkg::WindowDef,
  parameter int unsigned SAMPLE_BITS = tpet_pkg::SampleBitsDef
) (
  input  logic [SAMPLE_BITS-1:0] win_i [WINDOW],
  output logic [SAMPLE_BITS-1:0] med_o
);
  import tpet_pkg::*;

  localparam int unsigned RankW = $clog2(WINDOW + 1);
  localparam int unsigned Mid   = WINDOW / 2;

  logic [RankW-1:0] rank;

  // An entry's rank is the number of entries that sort ahead of it; equal
  // values are ordered by position so that exactly one entry has each rank.
  always_comb begin
    med_o = '0;
    rank  = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if ((win_i[j] < win_i[i]) || ((win_i[j] == win_i[i]) && (j < i))) begin
            rank = rank + RankW'(1);
          end
        end
      end
      if (rank == RankW'(Mid)) begin
        med_o = win_i[i];
      end
    end
  end

endmodule

FILE: hw/rtl/touch_pen_event_tracker.sv
// Touch pen event tracker: pen down, median-filtered move and pen up events.
// An accepted item is held in the input register, then its event, if any, is
// loaded into the result register. Throughput: one item per cycle while no
// stalled event holds up an item that emits; the median networks and state
// update are combinational between the input and result registers.
// Reset (asynchronous, active low): idle mode, counters cleared, threshold 5,
// release checks 3; sample windows are not cleared, they fill before use.
module touch_pen_event_tracker #(
  parameter int unsigned WINDOW      = tpet_pkg::WindowDef,
  parameter int unsigned SAMPLE_BITS = tpet_pkg::SampleBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tpet_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [tpet_pkg::CfgDataBits-1:0]   cfg_data_i,
  // Sample channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               in_pen_irq_i,
  input  logic [SAMPLE_BITS-1:0]             in_sample_x_i,
  input  logic [SAMPLE_BITS-1:0]             in_sample_y_i,
  input  logic [SAMPLE_BITS-1:0]             in_sample_z_i,
  // Event channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tpet_pkg::KindBits-1:0]      out_event_kind_o,
  output logic [SAMPLE_BITS-1:0]             out_pos_x_o,
  output logic [SAMPLE_BITS-1:0]             out_pos_y_o,
  output logic [SAMPLE_BITS-1:0]             out_pressure_o,
  output logic [tpet_pkg::IrqCntBits-1:0]    out_irq_total_o
);
  import tpet_pkg::*;

  // Width of the fill index: it only ever holds 0 .. WINDOW-1.
  localparam int unsigned IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // Common width for comparing samples against the threshold register.
  localparam int unsigned CmpW = (SAMPLE_BITS > ThreshBits) ? SAMPLE_BITS : ThreshBits;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; an index outside the
  // register list is dropped.
  // ---------------------------------------------------------------------------
  logic [ThreshBits-1:0]  thresh_q;
  logic [ReleaseBits-1:0] release_q;
  logic                   cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= ThreshReset;
      release_q <= ReleaseReset;
    end else if (cfg_we) begin
      if (cfg_index_i == CFG_TOUCH_THRESHOLD) begin
        thresh_q <= cfg_data_i[ThreshBits-1:0];
      end else if (cfg_index_i == CFG_RELEASE_CHECKS) begin
        release_q <= cfg_data_i[ReleaseBits-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. It drains whenever its item either produces no event or
  // the result register can take the event, so a waiting result only holds
  // up the item that would produce the next event.
  // ---------------------------------------------------------------------------
  logic                   s1_valid_q;
  logic                   s1_irq_q;
  logic [SAMPLE_BITS-1:0] s1_x_q;
  logic [SAMPLE_BITS-1:0] s1_y_q;
  logic [SAMPLE_BITS-1:0] s1_z_q;
  logic                   in_accept;
  logic                   s1_fire;
  logic                   out_free;
  logic                   emit;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_irq_q <= in_pen_irq_i;
      s1_x_q   <= in_sample_x_i;
      s1_y_q   <= in_sample_y_i;
      s1_z_q   <= in_sample_z_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Tracker state.
  // ---------------------------------------------------------------------------
  mode_e                   mode_q, mode_d;
  logic [IdxW-1:0]         fill_q, fill_d;
  logic [ReleaseBits-1:0]  low_q, low_d;
  logic [SAMPLE_BITS-1:0]  prev_x_q, prev_x_d;
  logic [SAMPLE_BITS-1:0]  prev_y_q, prev_y_d;
  logic [IrqCntBits-1:0]   irq_cnt_q, irq_cnt_d;

  // Sample windows; entries are written in order and the whole window is
  // always refilled before a median is taken from it.
  logic [SAMPLE_BITS-1:0]  x_win_q [WINDOW];
  logic [SAMPLE_BITS-1:0]  y_win_q [WINDOW];
  logic [SAMPLE_BITS-1:0]  z_win_q [WINDOW];
  logic [SAMPLE_BITS-1:0]  x_cur [WINDOW];
  logic [SAMPLE_BITS-1:0]  y_cur [WINDOW];
  logic [SAMPLE_BITS-1:0]  z_cur [WINDOW];
  logic                    win_we;

  // The median sees the window as it will be once the current sample lands,
  // so the last sample of a window is filtered in the same cycle.
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      if (IdxW'(k) == fill_q) begin
        x_cur[k] = s1_x_q;
        y_cur[k] = s1_y_q;
        z_cur[k] = s1_z_q;
      end else begin
        x_cur[k] = x_win_q[k];
        y_cur[k] = y_win_q[k];
        z_cur[k] = z_win_q[k];
      end
    end
  end

  logic [SAMPLE_BITS-1:0] med_x, med_y, med_z;

  tpet_median #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_med_x (
    .win_i (x_cur),
    .med_o (med_x)
  );

  tpet_median #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_med_y (
    .win_i (y_cur),
    .med_o (med_y)
  );

  tpet_median #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_med_z (
    .win_i (z_cur),
    .med_o (med_z)
  );

  // ---------------------------------------------------------------------------
  // Next state and event for the item in the input register.
  // ---------------------------------------------------------------------------
  logic                   sample_high;
  logic                   median_low;
  logic                   win_last;
  logic [ReleaseBits-1:0] low_inc;
  logic [ReleaseBits-1:0] need;
  logic [IrqCntBits-1:0]  irq_inc;
  event_kind_e            ev_kind;
  logic [SAMPLE_BITS-1:0] ev_x, ev_y, ev_z;
  logic [IrqCntBits-1:0]  ev_cnt;

  assign sample_high = CmpW'(s1_z_q) > CmpW'(thresh_q);
  assign median_low  = CmpW'(med_z) <= CmpW'(thresh_q);
  assign win_last    = fill_q == IdxW'(WINDOW - 1);
  assign low_inc     = low_q + ReleaseBits'(1);
  // A release count of zero behaves as one.
  assign need        = (release_q == '0) ? ReleaseBits'(1) : release_q;
  assign irq_inc     = irq_cnt_q + IrqCntBits'(1);

  always_comb begin
    mode_d    = mode_q;
    fill_d    = fill_q;
    low_d     = low_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    irq_cnt_d = irq_cnt_q;
    win_we    = 1'b0;
    emit      = 1'b0;
    ev_kind   = EV_MOVE;
    ev_x      = med_x;
    ev_y      = med_y;
    ev_z      = med_z;
    ev_cnt    = irq_cnt_q;
    unique case (mode_q)
      MODE_TRACK: begin
        win_we = 1'b1;
        if (!win_last) begin
          fill_d = fill_q + IdxW'(1);
        end else begin
          fill_d = '0;
          if (median_low) begin
            // Pressure has gone: start counting low samples toward pen up.
            mode_d = MODE_CONFIRM;
            low_d  = '0;
          end else if ((med_x != prev_x_q) || (med_y != prev_y_q)) begin
            // Only report a move when the filtered position has changed.
            prev_x_d = med_x;
            prev_y_d = med_y;
            emit     = 1'b1;
          end
        end
      end
      MODE_CONFIRM: begin
        if (sample_high) begin
          // Contact is back: resume tracking with a fresh window.
          mode_d = MODE_TRACK;
          fill_d = '0;
          low_d  = '0;
        end else if (low_inc >= need) begin
          // Release confirmed; the event carries the count before clearing.
          emit      = 1'b1;
          ev_kind   = EV_UP;
          ev_x      = '0;
          ev_y      = '0;
          ev_z      = '0;
          mode_d    = MODE_IDLE;
          low_d     = '0;
          irq_cnt_d = '0;
        end else begin
          low_d = low_inc;
        end
      end
      default: begin
        // Idle: only a pen interrupt matters.
        if (s1_irq_q) begin
          if (sample_high) begin
            emit      = 1'b1;
            ev_kind   = EV_DOWN;
            ev_x      = s1_x_q;
            ev_y      = s1_y_q;
            ev_z      = s1_z_q;
            ev_cnt    = irq_inc;
            irq_cnt_d = irq_inc;
            mode_d    = MODE_TRACK;
            fill_d    = '0;
            low_d     = '0;
          end else begin
            // Spurious interrupt: re-arm and forget the count.
            irq_cnt_d = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      fill_q    <= '0;
      low_q     <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      irq_cnt_q <= '0;
    end else if (s1_fire) begin
      mode_q    <= mode_d;
      fill_q    <= fill_d;
      low_q     <= low_d;
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
      irq_cnt_q <= irq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && win_we) begin
      x_win_q[fill_q] <= s1_x_q;
      y_win_q[fill_q] <= s1_y_q;
      z_win_q[fill_q] <= s1_z_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. A transaction completes when valid is high and the
  // receiver does not stall; a new event may load in that same cycle.
  // ---------------------------------------------------------------------------
  logic                   out_valid_q;
  event_kind_e            out_kind_q;
  logic [SAMPLE_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic [IrqCntBits-1:0]  out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_kind_q <= ev_kind;
      out_x_q    <= ev_x;
      out_y_q    <= ev_y;
      out_z_q    <= ev_z;
      out_cnt_q  <= ev_cnt;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_event_kind_o = out_kind_q;
  assign out_pos_x_o      = out_x_q;
  assign out_pos_y_o      = out_y_q;
  assign out_pressure_o   = out_z_q;
  assign out_irq_total_o  = out_cnt_q;

endmodule

FILE: hw/rtl/tpet_checker.sv
// Port-level checks for the touch pen event tracker, bound to the top level.
module tpet_checker #(
  parameter int unsigned SAMPLE_BITS = tpet_pkg::SampleBitsDef
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [tpet_pkg::KindBits-1:0]   out_event_kind_o,
  input logic [SAMPLE_BITS-1:0]          out_pos_x_o,
  input logic [SAMPLE_BITS-1:0]          out_pos_y_o,
  input logic [SAMPLE_BITS-1:0]          out_pressure_o,
  input logic [tpet_pkg::IrqCntBits-1:0] out_irq_total_o
);
  import tpet_pkg::*;

  // A stalled event stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_event_kind_o)
      && $stable(out_pos_x_o) && $stable(out_pos_y_o) && $stable(out_pressure_o)
      && $stable(out_irq_total_o))
    else $error("stalled event changed");

  // Pen up reports no position and no pressure.
  a_up_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_event_kind_o == EV_UP) |->
      (out_pos_x_o == '0) && (out_pos_y_o == '0) && (out_pressure_o == '0))
    else $error("pen up with nonzero fields");

  // Pen down and move only happen above the threshold, so pressure is nonzero.
  a_contact_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_event_kind_o == EV_DOWN) || (out_event_kind_o == EV_MOVE))
      |-> out_pressure_o != '0)
    else $error("contact event without pressure");

  // Every touch begins from a re-armed count, so exactly one interrupt is seen.
  a_irq_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_irq_total_o == IrqCntBits'(1))
    else $error("unexpected interrupt total");

endmodule

bind touch_pen_event_tracker tpet_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tpet_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_event_kind_o (out_event_kind_o),
  .out_pos_x_o      (out_pos_x_o),
  .out_pos_y_o      (out_pos_y_o),
  .out_pressure_o   (out_pressure_o),
  .out_irq_total_o  (out_irq_total_o)
);
